FILE: rtl/htfd_pkg.sv
// Shared types, constants and CRC helper for the humidity/temperature frame decoder.
package htfd_pkg;

  // CRC-8 parameters: polynomial 0x31, preset 0xFF, MSB first, no final xor
  localparam logic [7:0] CrcInit      = 8'hFF;
  localparam logic [7:0] CrcPoly      = 8'h31;

  // Status byte: busy clear, bits 4 and 3 set
  localparam logic [7:0] StatusMask   = 8'h98;
  localparam logic [7:0] StatusExpect = 8'h18;

  // Fixed-point conversion
  localparam int         RawW       = 20;
  localparam int         HumW       = 7;
  localparam int         TempW      = 15;
  localparam int         HumProdW   = RawW + HumW;     // raw * 100
  localparam int         TempProdW  = RawW + TempW;    // raw * 20000
  localparam logic [HumW-1:0]  HumScale   = 7'd100;
  localparam logic [TempW-1:0] TempScale  = 15'd20000; // 200 * 100
  localparam logic [TempW-1:0] TempOffset = 15'd5000;  // 50 * 100

  // One sensor frame
  typedef struct packed {
    logic [7:0] status_byte;
    logic [7:0] hum_high;
    logic [7:0] hum_mid;
    logic [7:0] mixed_byte;
    logic [7:0] temp_mid;
    logic [7:0] temp_low;
    logic [7:0] check_byte;
  } frame_t;

  // Frame check flags
  typedef struct packed {
    logic crc_ok;
    logic status_ok;
  } chk_t;

  // Fold one byte into the CRC, MSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CrcPoly) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

FILE: rtl/humidity_temp_frame_decode.sv
// Top level: input register, frame check and conversion, result register.
// Beat goes to stage 1, then to the result register (two register stages).
// One frame per cycle unless out_ready stalls; stage 1 fills while a result waits.
// Held humidity/temperature update only on frames that pass CRC and status.
// Reset (rst, synchronous): both stages empty, held values cleared to zero.
module humidity_temp_frame_decode
  import htfd_pkg::*;
(
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [7:0]              status_byte,
  input  logic [7:0]              hum_high,
  input  logic [7:0]              hum_mid,
  input  logic [7:0]              mixed_byte,
  input  logic [7:0]              temp_mid,
  input  logic [7:0]              temp_low,
  input  logic [7:0]              check_byte,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [HumW-1:0]         humidity_pct,
  output logic signed [TempW-1:0] temp_centi,
  output logic                    frame_ok
);

  logic                    s1_valid;
  frame_t                  s1_frame;
  logic                    s1_adv;
  chk_t                    chk;
  logic [HumW-1:0]         conv_hum;
  logic signed [TempW-1:0] conv_temp;
  logic                    frame_ok_next;
  logic [HumW-1:0]         held_humidity;
  logic signed [TempW-1:0] held_temp;
  logic [HumW-1:0]         held_humidity_next;
  logic signed [TempW-1:0] held_temp_next;

  // Handshake: stage 1 moves on when the result register is free or drains
  assign s1_adv   = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_adv;

  htfd_check u_check (
    .frame (s1_frame),
    .chk   (chk)
  );

  htfd_conv u_conv (
    .frame (s1_frame),
    .hum   (conv_hum),
    .temp  (conv_temp)
  );

  // Accept new values only on a clean frame
  assign frame_ok_next      = chk.crc_ok && chk.status_ok;
  assign held_humidity_next = frame_ok_next ? conv_hum  : held_humidity;
  assign held_temp_next     = frame_ok_next ? conv_temp : held_temp;

  // Control and held state
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid      <= 1'b0;
      out_valid     <= 1'b0;
      held_humidity <= '0;
      held_temp     <= '0;
    end else begin
      if (in_ready) begin
        s1_valid <= in_valid;
      end
      if (s1_adv) begin
        out_valid     <= 1'b1;
        held_humidity <= held_humidity_next;
        held_temp     <= held_temp_next;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_frame <= '{status_byte: status_byte, hum_high: hum_high, hum_mid: hum_mid,
                    mixed_byte: mixed_byte, temp_mid: temp_mid, temp_low: temp_low,
                    check_byte: check_byte};
    end
    if (s1_adv) begin
      humidity_pct <= held_humidity_next;
      temp_centi   <= held_temp_next;
      frame_ok     <= frame_ok_next;
    end
  end

  // A waiting result always shows the currently held values
  a_out_matches_held: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (humidity_pct == held_humidity) && (temp_centi == held_temp))
    else $error("result differs from held values");

  // Humidity stays within 0..99
  a_hum_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (humidity_pct <= 7'd99))
    else $error("humidity out of range");

  // Temperature stays within -5000..14999
  a_temp_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (temp_centi >= -15'sd5000) && (temp_centi <= 15'sd14999))
    else $error("temperature out of range");

  // With the result register empty, input is never stalled
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("input stalled with empty result register");

  // A rejected frame leaves held values untouched
  a_bad_frame_holds: assert property (@(posedge clk) disable iff (rst)
    s1_adv && !frame_ok_next |=> $stable(held_humidity) && $stable(held_temp))
    else $error("held values changed on bad frame");

endmodule

FILE: rtl/htfd_check.sv
// Frame integrity check: CRC-8 over bytes 0..5 and status byte pattern.
module htfd_check
  import htfd_pkg::*;
(
  input  frame_t frame,
  output chk_t   chk
);

  logic [7:0] crc_chain [0:6];

  // CRC over the six data bytes
  always_comb begin
    crc_chain[0] = CrcInit;
    crc_chain[1] = crc8_byte(crc_chain[0], frame.status_byte);
    crc_chain[2] = crc8_byte(crc_chain[1], frame.hum_high);
    crc_chain[3] = crc8_byte(crc_chain[2], frame.hum_mid);
    crc_chain[4] = crc8_byte(crc_chain[3], frame.mixed_byte);
    crc_chain[5] = crc8_byte(crc_chain[4], frame.temp_mid);
    crc_chain[6] = crc8_byte(crc_chain[5], frame.temp_low);
  end

  assign chk.crc_ok    = (crc_chain[6] == frame.check_byte);
  assign chk.status_ok = ((frame.status_byte & StatusMask) == StatusExpect);

endmodule

FILE: rtl/htfd_conv.sv
// Raw-to-engineering-unit conversion for humidity and temperature.
module htfd_conv
  import htfd_pkg::*;
(
  input  frame_t                  frame,
  output logic [HumW-1:0]         hum,
  output logic signed [TempW-1:0] temp
);

  logic [RawW-1:0]      hraw;
  logic [RawW-1:0]      traw;
  logic [HumProdW-1:0]  hprod;
  logic [TempProdW-1:0] tprod;
  logic [TempW-1:0]     tq;
  logic                 round_up;

  // Unpack the two 20-bit raws
  assign hraw = {frame.hum_high, frame.hum_mid, frame.mixed_byte[7:4]};
  assign traw = {frame.mixed_byte[3:0], frame.temp_mid, frame.temp_low};

  // Humidity: floor(raw * 100 / 2^20)
  assign hprod = HumProdW'(hraw) * HumProdW'(HumScale);
  assign hum   = hprod[HumProdW-1 -: HumW];

  // Temperature: floor(raw * 20000 / 2^20) - 5000, then bump by one when the
  // result is negative with a nonzero fraction (truncate toward zero)
  assign tprod    = TempProdW'(traw) * TempProdW'(TempScale);
  assign tq       = tprod[TempProdW-1 -: TempW];
  assign round_up = (tq < TempOffset) && (tprod[RawW-1:0] != '0);
  assign temp     = $signed(tq - TempOffset + TempW'(round_up));

endmodule

FILE: sim/tb_humidity_temp_frame_decode.sv
// Self-checking testbench for the humidity/temperature sensor frame decoder.
`timescale 1ns / 1ps

module tb_humidity_temp_frame_decode;
  import htfd_pkg::*;

  localparam int CycleLimit   = 200000;
  localparam int RandomFrames = 1930;
  localparam int HoldAfter    = 300;   // beats accepted before the long output stall
  localparam int LongHold     = 400;
  localparam int DrainCycles  = 20;

  // Fixed-point conversion terms
  localparam longint HumMul   = 100;
  localparam longint TempMul  = 20000;
  localparam longint TempBias = 64'sd5242880000;  // 50 C offset in hundredths, scaled by 2^20
  localparam longint RawSpan  = 1048576;

  // Raw values that sit on conversion boundaries
  localparam logic [RawW-1:0] RawMax      = 20'hFFFFF;
  localparam logic [RawW-1:0] RawTempZero = 20'd262144;
  localparam logic [RawW-1:0] RawTempNeg  = 20'd262143;

  typedef struct packed {
    logic [HumW-1:0]  humidity;
    logic [TempW-1:0] temp;
    logic             ok;
  } reading_t;

  typedef enum int {FR_GOOD, FR_BAD_CRC, FR_BAD_STATUS, FR_NOISE} frame_kind_e;
  typedef enum int {RX_STREAM, RX_COIN, RX_MOSTLY, RX_SPARSE} rx_mode_e;

  // Predicts decoded readings and checks them in order
  class reading_board;
    reading_t         expected_q[$];
    logic [HumW-1:0]  held_hum;
    logic [TempW-1:0] held_temp;
    int               errors;

    function new();
      held_hum  = '0;
      held_temp = '0;
      errors    = 0;
    endfunction

    // Bit-serial CRC-8 over bytes 0..5, MSB first
    function logic [7:0] frame_crc(frame_t f);
      logic [47:0] data;
      logic [7:0]  c;
      logic        fb;
      data = f[55:8];
      c    = CrcInit;
      for (int i = 47; i >= 0; i--) begin
        fb = c[7] ^ data[i];
        c  = {c[6:0], 1'b0} ^ (fb ? CrcPoly : 8'h00);
      end
      return c;
    endfunction

    function void note_frame(frame_t f);
      logic [RawW-1:0] hraw;
      logic [RawW-1:0] traw;
      longint          hnum;
      longint          tnum;
      reading_t        r;
      r.ok = (frame_crc(f) == f.check_byte) &&
             ((f.status_byte & StatusMask) == StatusExpect);
      if (r.ok) begin
        hraw = {f.hum_high, f.hum_mid, f.mixed_byte[7:4]};
        traw = {f.mixed_byte[3:0], f.temp_mid, f.temp_low};
        hnum = (longint'(hraw) * HumMul) >> RawW;
        // signed divide truncates toward zero
        tnum = (longint'(traw) * TempMul - TempBias) / RawSpan;
        held_hum  = hnum[HumW-1:0];
        held_temp = tnum[TempW-1:0];
      end
      r.humidity = held_hum;
      r.temp     = held_temp;
      expected_q.push_back(r);
    endfunction

    function void check_result(logic [HumW-1:0] hum, logic [TempW-1:0] temp, logic ok);
      reading_t r;
      if (expected_q.size() == 0) begin
        $error("unexpected result beat: humidity_pct %0d temp_centi %0d frame_ok %0b",
               hum, $signed(temp), ok);
        errors++;
        return;
      end
      r = expected_q.pop_front();
      if (hum !== r.humidity) begin
        $error("humidity_pct: expected %0d, got %0d", r.humidity, hum);
        errors++;
      end
      if (temp !== r.temp) begin
        $error("temp_centi: expected %0d, got %0d", $signed(r.temp), $signed(temp));
        errors++;
      end
      if (ok !== r.ok) begin
        $error("frame_ok: expected %0b, got %0b", r.ok, ok);
        errors++;
      end
    endfunction

    function int pending();
      return expected_q.size();
    endfunction
  endclass

  logic                    clk = 1'b0;
  logic                    rst = 1'b1;
  logic                    in_valid = 1'b0;
  logic                    in_ready;
  logic [7:0]              status_byte = '0;
  logic [7:0]              hum_high = '0;
  logic [7:0]              hum_mid = '0;
  logic [7:0]              mixed_byte = '0;
  logic [7:0]              temp_mid = '0;
  logic [7:0]              temp_low = '0;
  logic [7:0]              check_byte = '0;
  logic                    out_valid;
  logic                    out_ready = 1'b0;
  logic [HumW-1:0]         humidity_pct;
  logic signed [TempW-1:0] temp_centi;
  logic                    frame_ok;

  reading_board sb = new();
  int           frames_accepted = 0;

  humidity_temp_frame_decode dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .status_byte  (status_byte),
    .hum_high     (hum_high),
    .hum_mid      (hum_mid),
    .mixed_byte   (mixed_byte),
    .temp_mid     (temp_mid),
    .temp_low     (temp_low),
    .check_byte   (check_byte),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .humidity_pct (humidity_pct),
    .temp_centi   (temp_centi),
    .frame_ok     (frame_ok)
  );

  always begin
    clk = 1'b0;
    #1;
    clk = 1'b1;
    #1;
  end

  // Build a frame from raws; check byte is correct unless corrupted
  function automatic frame_t make_frame(logic [7:0] status, logic [RawW-1:0] hraw,
                                        logic [RawW-1:0] traw, bit corrupt_crc);
    frame_t f;
    f.status_byte = status;
    f.hum_high    = hraw[19:12];
    f.hum_mid     = hraw[11:4];
    f.mixed_byte  = {hraw[3:0], traw[19:16]};
    f.temp_mid    = traw[15:8];
    f.temp_low    = traw[7:0];
    f.check_byte  = sb.frame_crc(f);
    if (corrupt_crc)
      f.check_byte ^= 8'($urandom_range(1, 255));
    return f;
  endfunction

  // Mostly uniform raw, sometimes a boundary value
  function automatic logic [RawW-1:0] pick_raw();
    case ($urandom_range(0, 19))
      0:       return '0;
      1:       return RawMax;
      2:       return RawTempNeg;
      3:       return RawTempZero;
      default: return RawW'($urandom());
    endcase
  endfunction

  function automatic frame_t random_frame();
    frame_kind_e kind;
    logic [7:0]  status;
    frame_t      f;
    case ($urandom_range(0, 9))
      0:       kind = FR_BAD_CRC;
      1:       kind = FR_BAD_STATUS;
      2:       kind = FR_NOISE;
      default: kind = FR_GOOD;
    endcase
    status = 8'($urandom());
    if (kind == FR_BAD_STATUS) begin
      while ((status & StatusMask) == StatusExpect)
        status = 8'($urandom());
    end else if (kind != FR_NOISE) begin
      status = (status & ~StatusMask) | StatusExpect;
    end
    if (kind == FR_NOISE) begin
      f = frame_t'({$urandom(), 24'($urandom())});
    end else begin
      f = make_frame(status, pick_raw(), pick_raw(), kind == FR_BAD_CRC);
    end
    return f;
  endfunction

  // Hold one input beat until it is taken
  task automatic drive_frame(input frame_t f);
    in_valid    <= 1'b1;
    status_byte <= f.status_byte;
    hum_high    <= f.hum_high;
    hum_mid     <= f.hum_mid;
    mixed_byte  <= f.mixed_byte;
    temp_mid    <= f.temp_mid;
    temp_low    <= f.temp_low;
    check_byte  <= f.check_byte;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // Monitor both channels
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        sb.note_frame({status_byte, hum_high, hum_mid, mixed_byte,
                       temp_mid, temp_low, check_byte});
        frames_accepted++;
      end
      if (out_valid && out_ready)
        sb.check_result(humidity_pct, temp_centi, frame_ok);
    end
  end

  // Output backpressure: random segments plus one long stall
  initial begin : receiver
    rx_mode_e mode;
    int       seg_len;
    bit       long_hold_done;
    long_hold_done = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (!long_hold_done && frames_accepted >= HoldAfter) begin
        out_ready <= 1'b0;
        repeat (LongHold) @(posedge clk);
        long_hold_done = 1'b1;
      end
      mode    = rx_mode_e'($urandom_range(0, 3));
      seg_len = $urandom_range(10, 150);
      repeat (seg_len) begin
        case (mode)
          RX_STREAM: out_ready <= 1'b1;
          RX_COIN:   out_ready <= 1'($urandom_range(0, 1));
          RX_MOSTLY: out_ready <= ($urandom_range(0, 9) != 0);
          RX_SPARSE: out_ready <= ($urandom_range(0, 7) == 0);
        endcase
        @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    int cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk);
      cycles++;
    end
    $display("status: fail");
    $finish;
  end

  initial begin : stimulus
    frame_t stim_q[$];
    int     burst_left;
    int     gap;

    // Directed frames
    stim_q.push_back(make_frame(StatusExpect, '0, '0, 1'b0));          // coldest, driest
    stim_q.push_back(make_frame(StatusExpect, RawMax, RawMax, 1'b0));  // top of range
    stim_q.push_back(make_frame(8'h1C, 20'h80000, RawTempZero, 1'b0)); // exactly 0 C
    stim_q.push_back(make_frame(8'h1A, 20'd10485, RawTempNeg, 1'b0));  // trunc to 0, not -1
    stim_q.push_back(make_frame(8'h19, 20'd10486, 20'd262090, 1'b0));  // trunc to -1
    stim_q.push_back(make_frame(8'h7F, 20'h12345, 20'd1, 1'b0));       // spare status bits set
    stim_q.push_back(make_frame(StatusExpect, 20'h54321, 20'hABCDE, 1'b1)); // bad CRC holds
    stim_q.push_back(make_frame(8'h98, 20'h11111, 20'h22222, 1'b0));   // busy
    stim_q.push_back(make_frame(8'h08, 20'h33333, 20'h44444, 1'b0));   // bit 4 clear
    stim_q.push_back(make_frame(8'h10, 20'h55555, 20'h66666, 1'b0));   // bit 3 clear
    stim_q.push_back(make_frame(8'hFF, RawMax, RawMax, 1'b0));         // busy with all set
    stim_q.push_back(frame_t'('0));
    stim_q.push_back(frame_t'({56{1'b1}}));
    stim_q.push_back(make_frame(8'h18, 20'hAAAAA, 20'h55555, 1'b0));
    stim_q.push_back(make_frame(8'hE7, 20'h55555, 20'hAAAAA, 1'b1));   // bad both ways
    stim_q.push_back(make_frame(8'h1F, 20'h0F0F0, 20'hF0F0F, 1'b0));
    stim_q.push_back(make_frame(StatusExpect, RawMax, '0, 1'b0));
    stim_q.push_back(make_frame(StatusExpect, '0, RawMax, 1'b0));

    for (int i = 0; i < RandomFrames; i++)
      stim_q.push_back(random_frame());

    rst <= 1'b1;
    repeat (10) @(posedge clk);
    rst <= 1'b0;

    // Bursts of random length with random gaps between them
    burst_left = 0;
    foreach (stim_q[i]) begin
      if (burst_left == 0) begin
        burst_left = $urandom_range(1, 40);
        gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_valid <= 1'b0;
          repeat (gap) @(posedge clk);
        end
      end
      drive_frame(stim_q[i]);
      burst_left--;
    end
    in_valid <= 1'b0;

    // Let the monitor log the last accepted beat before counting what is left
    @(posedge clk);
    while (sb.pending() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    if (sb.errors == 0)
      $display("status: pass");
    else
      $display("status: fail");
    $finish;
  end

endmodule

FILE: humidity_temp_frame_decode.f
rtl/htfd_pkg.sv
rtl/htfd_check.sv
rtl/htfd_conv.sv
rtl/humidity_temp_frame_decode.sv
sim/tb_humidity_temp_frame_decode.sv
